[sv/wsg_pkg.sv]
// wsg_pkg: shared constants, types and a helper function of the wavetable sound generator
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies

package wsg_pkg;

  // item operation codes
  localparam logic [2:0] FUNC_REG_WR   = 3'd0;
  localparam logic [2:0] FUNC_WAVE_WR  = 3'd1;
  localparam logic [2:0] FUNC_BURST_WR = 3'd2;
  localparam logic [2:0] FUNC_TRIGGER  = 3'd3;
  localparam logic [2:0] FUNC_TICK     = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST   = 2'd2;

  // field widths
  localparam int FUNC_W   = 3;
  localparam int RIDX_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int WSEL_W   = 3;
  localparam int POS_W    = 12;
  localparam int PCM_W    = 16;
  localparam int PCT_W    = 7;
  localparam int BLEN_W   = 13;

  // sound register file and waveform store
  localparam int SREG_DEPTH = 32;
  localparam int WAVE_LEN   = 32;
  localparam int WAVE_AW    = WSEL_W + $clog2(WAVE_LEN);
  localparam int WAVE_DEPTH = 1 << WAVE_AW;

  // voices; only phase bits 17:13 are ever looked at, so 18 bits of phase suffice
  localparam int VOICES   = 3;
  localparam logic [1:0] VOICE_LAST = 2'd2;
  localparam int PHASE_W  = 18;
  localparam int PHASE_LO = 13;

  // arithmetic widths: three 255 x 128 products plus one burst byte fit 19 bits signed
  localparam int PROD_W   = BYTE_W + 1 + BYTE_W;
  localparam int ACC_W    = 19;
  localparam int SCALE_W  = 7;
  localparam int SCALED_W = ACC_W + SCALE_W + 1;

  // scale = floor(64 * percent / 100) = (percent * 10486) >> 14 for every 7-bit percent
  localparam int RECIP_W   = 21;
  localparam int RECIP_SH  = 14;
  localparam logic [RECIP_W-1:0] SCALE_RECIP = 21'd10486;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 7'd64;

  // burst defaults
  localparam int BURST_DEPTH_DEF = 4096;
  localparam logic [BLEN_W-1:0] BLEN_RST = 13'd4096;

  // saturation limits
  localparam logic [PCM_W-1:0] PCM_MAX = 16'h7fff;
  localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;

  // controller to datapath commands
  typedef struct packed {
    logic       accept;      // an input item is taken this cycle
    logic       tick_start;  // decode the register file and latch the voices
    logic       burst_step;  // seed the sum with the burst byte and advance the burst
    logic       mac;         // add one voice product
    logic [1:0] rd_sel;      // voice whose waveform entry is fetched
    logic [1:0] mac_sel;     // voice whose product is added
    logic       scale;       // apply master volume
    logic       load_out;    // saturate into the output register, advance phases
  } wsg_cmd_t;

  function automatic logic [SCALE_W-1:0] pct_to_scale(input logic [PCT_W-1:0] pct);
    logic [RECIP_W-1:0] p;
    p = RECIP_W'(pct) * SCALE_RECIP;
    return p[RECIP_SH +: SCALE_W];
  endfunction

endpackage

[sv/wsg_if.sv]
// wsg_in_if and wsg_out_if: valid/ready channels for input items and result items
// depends on wsg_pkg for field widths

interface wsg_in_if;
  logic                              valid;
  logic                              ready;
  logic [wsg_pkg::FUNC_W-1:0]        func;
  logic [wsg_pkg::RIDX_W-1:0]        reg_index;
  logic [wsg_pkg::BYTE_W-1:0]        reg_value;
  logic [wsg_pkg::WSEL_W-1:0]        wave_select;
  logic [wsg_pkg::POS_W-1:0]         table_position;
  logic signed [wsg_pkg::BYTE_W-1:0] sample_value;
  logic                              game_running;

  modport source (
    output valid, func, reg_index, reg_value, wave_select, table_position,
           sample_value, game_running,
    input  ready
  );
  modport sink (
    input  valid, func, reg_index, reg_value, wave_select, table_position,
           sample_value, game_running,
    output ready
  );
endinterface

interface wsg_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wsg_pkg::PCM_W-1:0] pcm_sample;
  logic                             clipped;

  modport source (
    output valid, pcm_sample, clipped,
    input  ready
  );
  modport sink (
    input  valid, pcm_sample, clipped,
    output ready
  );
endinterface

[sv/wsg_ctrl.sv]
// wsg_ctrl: sequencer of the wavetable sound generator, one sample tick at a time
// depends on wsg_pkg for operation codes and the command struct

module wsg_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [wsg_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output wsg_pkg::wsg_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] vcnt_r, vcnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_ready_c;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    vcnt_nxt   = vcnt_r;
    in_ready_c = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready_c = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && (in_func == wsg_pkg::FUNC_TICK)) begin
          cmd.tick_start = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.burst_step = 1'b1;
        cmd.rd_sel     = 2'd0;
        state_nxt      = S_MAC;
      end
      S_MAC: begin
        cmd.mac     = 1'b1;
        cmd.mac_sel = vcnt_r;
        cmd.rd_sel  = vcnt_r + 2'd1;
        if (vcnt_r == wsg_pkg::VOICE_LAST) begin
          vcnt_nxt  = 2'd0;
          state_nxt = S_SCALE;
        end else begin
          vcnt_nxt = vcnt_r + 2'd1;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        vcnt_nxt  = 2'd0;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_c;
  assign out_valid = out_valid_r;

  // a tick taken in idle starts the fetch right away
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == wsg_pkg::FUNC_TICK)) |=> (state_r == S_READ))
    else $error("tick item did not start the sequence");

  // voice counter only moves while accumulating
  a_vcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MAC) |-> (vcnt_r == 2'd0))
    else $error("voice counter left nonzero outside accumulation");

  // a finished tick waits while the earlier result is still held
  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT))
    else $error("result overwrote a pending item");

  // a new result only comes from the output stage
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output stage");

endmodule

[sv/wsg_dp.sv]
// wsg_dp: datapath of the wavetable sound generator: register file, tables, voices, mixer
// depends on wsg_pkg and on wsg_in_if for the input payload

module wsg_dp #(
  parameter int BURST_DEPTH = wsg_pkg::BURST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wsg_in_if.sink                              in_ch,
  input  wsg_pkg::wsg_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [wsg_pkg::PCM_W-1:0]    pcm_sample,
  output logic                                clipped
);

  localparam int PTR_W = $clog2(BURST_DEPTH);
  localparam int LEN_W = $clog2(BURST_DEPTH + 1);
  localparam int REM_W = LEN_W + 1;
  localparam int CMP_W = ((LEN_W > wsg_pkg::BLEN_W) ? LEN_W : wsg_pkg::BLEN_W) + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BURST_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BURST_DEPTH - 1);

  // configuration
  logic                        layout_r;
  logic [wsg_pkg::SCALE_W-1:0] scale_r;
  logic [wsg_pkg::BLEN_W-1:0]  blen_r;

  // sound register file and voice state
  logic [7:0]                  sreg_r  [wsg_pkg::SREG_DEPTH];
  logic [wsg_pkg::PHASE_W-1:0] phase_r [wsg_pkg::VOICES];
  logic [wsg_pkg::PHASE_W-1:0] step_r  [wsg_pkg::VOICES];
  logic [wsg_pkg::WSEL_W-1:0]  wave_r  [wsg_pkg::VOICES];
  logic [7:0]                  level_r [wsg_pkg::VOICES];

  // decoded voice fields for the current register contents
  logic [wsg_pkg::PHASE_W-1:0] dec_step  [wsg_pkg::VOICES];
  logic [wsg_pkg::WSEL_W-1:0]  dec_wave  [wsg_pkg::VOICES];
  logic [7:0]                  dec_level [wsg_pkg::VOICES];

  // tables
  logic [7:0]                  wmem [wsg_pkg::WAVE_DEPTH];
  logic [7:0]                  bmem [BURST_DEPTH];
  logic signed [7:0]           wq_r;
  logic signed [7:0]           bq_r;
  logic [wsg_pkg::WAVE_AW-1:0] wrd_addr;

  // burst player
  logic [REM_W-1:0]            rem_r;
  logic [PTR_W-1:0]            ptr_r;
  logic [CMP_W-1:0]            pos_wide;
  logic [CMP_W-1:0]            blen_wide;
  logic [LEN_W-1:0]            len_eff;

  // mixer
  logic signed [wsg_pkg::ACC_W-1:0]    acc_r;
  logic signed [wsg_pkg::SCALED_W-1:0] scaled_r;
  logic signed [wsg_pkg::PROD_W-1:0]   prod;
  logic [7:0]                          mac_level;
  logic                                sat_hi, sat_lo;
  logic [wsg_pkg::PCM_W-1:0]           pcm_r;
  logic                                clip_r;

  logic                                do_reg_wr, do_wave_wr, do_burst_wr, do_trigger;

  // item decode
  assign do_reg_wr   = cmd.accept && (in_ch.func == wsg_pkg::FUNC_REG_WR);
  assign do_wave_wr  = cmd.accept && (in_ch.func == wsg_pkg::FUNC_WAVE_WR)
                       && (in_ch.table_position < wsg_pkg::POS_W'(wsg_pkg::WAVE_LEN));
  assign pos_wide    = CMP_W'(in_ch.table_position);
  assign do_burst_wr = cmd.accept && (in_ch.func == wsg_pkg::FUNC_BURST_WR)
                       && (pos_wide < DEPTH_C);
  assign do_trigger  = cmd.accept && (in_ch.func == wsg_pkg::FUNC_TRIGGER)
                       && in_ch.game_running;

  // burst length capped at the table depth
  assign blen_wide = CMP_W'(blen_r);
  assign len_eff   = (blen_wide > DEPTH_C) ? LEN_W'(BURST_DEPTH) : LEN_W'(blen_r);

  // voice decode in both register layouts
  for (genvar c = 0; c < wsg_pkg::VOICES; c++) begin : g_dec
    localparam int B = c * 5;
    logic [wsg_pkg::PHASE_W-1:0] step0, step1, base0;

    assign base0 = (c == 0) ? wsg_pkg::PHASE_W'(sreg_r[16]) : '0;
    assign step0 = base0
                 + wsg_pkg::PHASE_W'({sreg_r[B + 17], 4'b0})
                 + wsg_pkg::PHASE_W'({sreg_r[B + 18], 8'b0})
                 + wsg_pkg::PHASE_W'({sreg_r[B + 19], 12'b0})
                 + wsg_pkg::PHASE_W'({sreg_r[B + 20], 16'b0});
    // nibble layout: fields overlap and are ORed, then shifted up by four
    assign step1 = wsg_pkg::PHASE_W'({sreg_r[B + 0], 4'b0})
                 | wsg_pkg::PHASE_W'({sreg_r[B + 1], 8'b0})
                 | wsg_pkg::PHASE_W'({sreg_r[B + 2], 12'b0})
                 | wsg_pkg::PHASE_W'({sreg_r[B + 3], 16'b0});

    assign dec_step[c]  = layout_r ? step1 : step0;
    assign dec_wave[c]  = layout_r ? sreg_r[B + 4][3:1] : sreg_r[B + 5][2:0];
    assign dec_level[c] = layout_r ? {4'b0, sreg_r[B + 5][3:0]} : sreg_r[B + 21];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= 1'b0;
      scale_r  <= wsg_pkg::SCALE_RST;
      blen_r   <= wsg_pkg::BLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wsg_pkg::CFG_LAYOUT:  layout_r <= cfg_data[0];
        wsg_pkg::CFG_PERCENT: scale_r  <= wsg_pkg::pct_to_scale(cfg_data[wsg_pkg::PCT_W-1:0]);
        wsg_pkg::CFG_BURST:   blen_r   <= cfg_data[wsg_pkg::BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sound register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wsg_pkg::SREG_DEPTH; i++) begin
        sreg_r[i] <= 8'd0;
      end
    end else if (do_reg_wr) begin
      sreg_r[in_ch.reg_index] <= in_ch.reg_value;
    end
  end

  // voice latch on tick, phase advance once the result is stored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < wsg_pkg::VOICES; c++) begin
        phase_r[c] <= '0;
        step_r[c]  <= '0;
        wave_r[c]  <= '0;
        level_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < wsg_pkg::VOICES; c++) begin
        if (cmd.tick_start) begin
          level_r[c] <= dec_level[c];
          if (dec_level[c] != 8'd0) begin
            step_r[c] <= dec_step[c];
            wave_r[c] <= dec_wave[c];
          end
        end
        if (cmd.load_out) begin
          phase_r[c] <= phase_r[c] + step_r[c];
        end
      end
    end
  end

  // waveform table, one read port
  always_comb begin
    case (cmd.rd_sel)
      2'd1:    wrd_addr = {wave_r[1], phase_r[1][wsg_pkg::PHASE_LO +: 5]};
      2'd2:    wrd_addr = {wave_r[2], phase_r[2][wsg_pkg::PHASE_LO +: 5]};
      default: wrd_addr = {wave_r[0], phase_r[0][wsg_pkg::PHASE_LO +: 5]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wave_wr) begin
      wmem[{in_ch.wave_select, in_ch.table_position[4:0]}] <= in_ch.sample_value;
    end
    wq_r <= wmem[wrd_addr];
  end

  // burst table, read at the play pointer every cycle
  always_ff @(posedge clk) begin
    if (do_burst_wr) begin
      bmem[pos_wide[PTR_W-1:0]] <= in_ch.sample_value;
    end
    bq_r <= bmem[ptr_r];
  end

  // burst player: each byte plays on two ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ptr_r <= '0;
    end else if (do_trigger) begin
      rem_r <= {len_eff, 1'b0};
      ptr_r <= '0;
    end else if (cmd.burst_step && (rem_r != '0)) begin
      rem_r <= rem_r - REM_W'(1);
      if (rem_r[0]) begin
        ptr_r <= (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
      end
    end
  end

  // shared voice multiplier
  always_comb begin
    case (cmd.mac_sel)
      2'd1:    mac_level = level_r[1];
      2'd2:    mac_level = level_r[2];
      default: mac_level = level_r[0];
    endcase
  end

  assign prod = $signed({1'b0, mac_level}) * wq_r;

  // accumulate burst byte and voices, then master volume
  always_ff @(posedge clk) begin
    if (cmd.burst_step) begin
      acc_r <= (rem_r != '0) ? wsg_pkg::ACC_W'(bq_r) : '0;
    end else if (cmd.mac && (mac_level != 8'd0)) begin
      acc_r <= acc_r + wsg_pkg::ACC_W'(prod);
    end
    if (cmd.scale) begin
      scaled_r <= acc_r * $signed({1'b0, scale_r});
    end
  end

  // saturation to 16 bits
  assign sat_hi = !scaled_r[wsg_pkg::SCALED_W-1]
                  && (|scaled_r[wsg_pkg::SCALED_W-2:wsg_pkg::PCM_W-1]);
  assign sat_lo = scaled_r[wsg_pkg::SCALED_W-1]
                  && !(&scaled_r[wsg_pkg::SCALED_W-2:wsg_pkg::PCM_W-1]);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      clip_r <= sat_hi || sat_lo;
      if (sat_hi) begin
        pcm_r <= wsg_pkg::PCM_MAX;
      end else if (sat_lo) begin
        pcm_r <= wsg_pkg::PCM_MIN;
      end else begin
        pcm_r <= scaled_r[wsg_pkg::PCM_W-1:0];
      end
    end
  end

  assign pcm_sample = $signed(pcm_r);
  assign clipped    = clip_r;

endmodule

[sv/wavetable_sound_generator_unit.sv]
// Three-voice wavetable sound generator. Register, table and trigger items are taken when
// the sequencer is idle. A sample tick item runs from acceptance to a result in the output
// register: acceptance with register decode, burst fetch, a step for each voice through the
// single shared level x sample multiplier and the one-port waveform table, master volume,
// and saturation. The next item is accepted as soon as the tick has been stored, even while
// the result waits; a tick that finds the output register still full holds in its last cycle.
// Waveform and burst tables are not cleared at reset, so a tick must only read entries that
// were loaded. No clearing pass follows reset.
// depends on wsg_pkg, wsg_if, wsg_ctrl and wsg_dp

module wavetable_sound_generator_unit #(
  parameter int BURST_DEPTH = wsg_pkg::BURST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wsg_in_if.sink                         in_ch,
  wsg_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0] cfg_data
);

  wsg_pkg::wsg_cmd_t cmd;
  logic              in_ready;

  // sequencer
  wsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath
  wsg_dp #(
    .BURST_DEPTH (BURST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pcm_sample (out_ch.pcm_sample),
    .clipped    (out_ch.clipped)
  );

endmodule

[tb/wavetable_sound_generator_unit_test.sv]
`timescale 1ns / 100ps

// wavetable_sound_generator_unit_test: self-checking bench for the wavetable sound generator
// pushes register, table, trigger and tick items through the input channel and compares every
// sample with a mixer model of its own; depends on wsg_pkg, wsg_if and the generator rtl

module wavetable_sound_generator_unit_test;

  localparam logic [wsg_pkg::FUNC_W-1:0]    FUNC_SPARE_LO   = 3'd5;
  localparam logic [wsg_pkg::FUNC_W-1:0]    FUNC_SPARE_HI   = 3'd7;
  localparam logic [wsg_pkg::CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
  localparam int                            BURST_SLOTS     = wsg_pkg::BURST_DEPTH_DEF;
  localparam int                            DRAIN_CYCLES    = 16;
  localparam int                            ITEMS_PER_PHASE = 200;
  localparam int                            PLAN_LEN        = 6;

  typedef struct packed {
    logic [wsg_pkg::FUNC_W-1:0]        func;
    logic [wsg_pkg::RIDX_W-1:0]        reg_index;
    logic [wsg_pkg::BYTE_W-1:0]        reg_value;
    logic [wsg_pkg::WSEL_W-1:0]        wave_select;
    logic [wsg_pkg::POS_W-1:0]         table_position;
    logic signed [wsg_pkg::BYTE_W-1:0] sample_value;
    logic                              game_running;
  } wsg_item_t;

  typedef struct packed {
    logic signed [wsg_pkg::PCM_W-1:0] pcm;
    logic                             clipped;
  } wsg_sample_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [wsg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wsg_pkg::CFG_DATA_W-1:0] cfg_data;

  wsg_in_if  in_ch ();
  wsg_out_if out_ch ();

  wavetable_sound_generator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mixer model state
  logic [wsg_pkg::BYTE_W-1:0]        snd_reg     [wsg_pkg::SREG_DEPTH];
  logic signed [wsg_pkg::BYTE_W-1:0] wave_mem    [wsg_pkg::WAVE_DEPTH];
  logic signed [wsg_pkg::BYTE_W-1:0] burst_mem   [BURST_SLOTS];
  logic [31:0]                       voice_phase [wsg_pkg::VOICES];
  logic [23:0]                       voice_step  [wsg_pkg::VOICES];
  logic [wsg_pkg::WSEL_W-1:0]        voice_wave  [wsg_pkg::VOICES];
  logic [wsg_pkg::BYTE_W-1:0]        voice_level [wsg_pkg::VOICES];
  logic [13:0]                       burst_left;
  logic [wsg_pkg::POS_W-1:0]         burst_ptr;
  logic                              layout_q;
  logic [wsg_pkg::PCT_W-1:0]         percent_q;
  logic [wsg_pkg::BLEN_W-1:0]        burst_len_q;

  wsg_sample_t pending_samples [$];
  wsg_item_t   item_backlog [$];

  int errors          = 0;
  int items_sent      = 0;
  int samples_checked = 0;
  int samples_clipped = 0;
  int cfg_writes      = 0;
  int gen_count       = 0;

  // stimulus-side view of the burst, so a tick never reads an unloaded burst byte
  logic                       gen_layout;
  logic [wsg_pkg::BLEN_W-1:0] gen_burst_len;
  int                         gen_burst_left = 0;
  int                         gen_burst_ptr  = 0;
  bit                         burst_loaded [BURST_SLOTS];

  // register settings walked through after the reset phase
  bit          layout_plan  [PLAN_LEN] = '{1, 0, 1, 0, 1, 0};
  int unsigned percent_plan [PLAN_LEN] = '{100, 0, 127, 37, 1, 64};
  int unsigned blen_plan    [PLAN_LEN] = '{24, 1, 8191, 0, 4096, 48};

  // one sample tick: decode voices, mix, scale, saturate, advance phases
  task automatic mix_sample();
    int                         acc;
    int                         scale;
    int                         b;
    logic [wsg_pkg::BYTE_W-1:0] lvl;
    logic [31:0]                stp;
    logic [wsg_pkg::WSEL_W-1:0] wv;
    wsg_sample_t                s;
    scale = (64 * int'(percent_q)) / 100;
    acc = 0;
    for (int c = 0; c < wsg_pkg::VOICES; c++) begin
      b = 5 * c;
      if (layout_q) begin
        lvl = snd_reg[b + 5] & 8'h0f;
        stp = 32'(snd_reg[b]) | (32'(snd_reg[b + 1]) << 4) | (32'(snd_reg[b + 2]) << 8)
            | (32'(snd_reg[b + 3]) << 12) | (32'(snd_reg[b + 4][0]) << 16);
        stp = stp << 4;
        wv = snd_reg[b + 4][3:1];
      end else begin
        lvl = snd_reg[b + 'h15];
        stp = (c == 0) ? 32'(snd_reg['h10]) : 32'd0;
        stp += 32'(snd_reg[b + 'h11]) << 4;
        stp += 32'(snd_reg[b + 'h12]) << 8;
        stp += 32'(snd_reg[b + 'h13]) << 12;
        stp += 32'(snd_reg[b + 'h14]) << 16;
        wv = snd_reg[b + 5][wsg_pkg::WSEL_W-1:0];
      end
      voice_level[c] = lvl;
      // a silent voice keeps its previous step and waveform
      if (lvl != 0) begin
        voice_step[c] = stp[23:0];
        voice_wave[c] = wv;
      end
    end
    for (int c = 0; c < wsg_pkg::VOICES; c++) begin
      if (voice_level[c] != 0)
        acc += int'(voice_level[c])
             * int'(wave_mem[{voice_wave[c], voice_phase[c][wsg_pkg::PHASE_LO +: 5]}]);
    end
    // each burst byte plays on two ticks
    if (burst_left != 0) begin
      acc += int'(burst_mem[burst_ptr]);
      if (burst_left[0])
        burst_ptr = burst_ptr + 1'b1;
      burst_left = burst_left - 1'b1;
    end
    acc = acc * scale;
    if (acc > 32767) begin
      s.pcm = wsg_pkg::PCM_MAX;
      s.clipped = 1'b1;
    end else if (acc < -32768) begin
      s.pcm = wsg_pkg::PCM_MIN;
      s.clipped = 1'b1;
    end else begin
      s.pcm = wsg_pkg::PCM_W'(acc);
      s.clipped = 1'b0;
    end
    pending_samples.push_back(s);
    for (int c = 0; c < wsg_pkg::VOICES; c++)
      voice_phase[c] = voice_phase[c] + 32'(voice_step[c]);
  endtask

  // model update for one accepted item
  task automatic apply_item(input wsg_item_t it);
    case (it.func)
      wsg_pkg::FUNC_REG_WR: snd_reg[it.reg_index] = it.reg_value;
      wsg_pkg::FUNC_WAVE_WR: begin
        if (it.table_position < wsg_pkg::WAVE_LEN)
          wave_mem[{it.wave_select, it.table_position[4:0]}] = it.sample_value;
      end
      wsg_pkg::FUNC_BURST_WR: begin
        if (it.table_position < BURST_SLOTS)
          burst_mem[it.table_position] = it.sample_value;
      end
      wsg_pkg::FUNC_TRIGGER: begin
        if (it.game_running) begin
          burst_left = (burst_len_q > BURST_SLOTS) ? 14'(2 * BURST_SLOTS)
                                                   : {burst_len_q, 1'b0};
          burst_ptr = '0;
        end
      end
      wsg_pkg::FUNC_TICK: mix_sample();
      default: ;
    endcase
  endtask

  // item with every field random apart from the operation
  function automatic wsg_item_t make_item(input logic [wsg_pkg::FUNC_W-1:0] f);
    logic [63:0] bits;
    wsg_item_t   it;
    bits = {$urandom, $urandom};
    it = bits[$bits(wsg_item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  // queue an item, loading the burst byte a tick is about to play if it is still empty
  task automatic queue_item(input wsg_item_t it);
    wsg_item_t fill;
    if (it.func == wsg_pkg::FUNC_TICK && gen_burst_left != 0
        && !burst_loaded[gen_burst_ptr]) begin
      fill = make_item(wsg_pkg::FUNC_BURST_WR);
      fill.table_position = wsg_pkg::POS_W'(gen_burst_ptr);
      item_backlog.push_back(fill);
      burst_loaded[gen_burst_ptr] = 1'b1;
      gen_count++;
    end
    item_backlog.push_back(it);
    gen_count++;
    case (it.func)
      wsg_pkg::FUNC_BURST_WR: burst_loaded[it.table_position] = 1'b1;
      wsg_pkg::FUNC_TRIGGER: begin
        if (it.game_running) begin
          gen_burst_left = 2 * ((gen_burst_len > BURST_SLOTS) ? BURST_SLOTS
                                                               : int'(gen_burst_len));
          gen_burst_ptr = 0;
        end
      end
      wsg_pkg::FUNC_TICK: begin
        if (gen_burst_left != 0) begin
          if (gen_burst_left % 2 == 1)
            gen_burst_ptr = (gen_burst_ptr + 1) % BURST_SLOTS;
          gen_burst_left--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_reg(input int idx, input int val);
    wsg_item_t it;
    it = make_item(wsg_pkg::FUNC_REG_WR);
    it.reg_index = wsg_pkg::RIDX_W'(idx);
    it.reg_value = wsg_pkg::BYTE_W'(val);
    queue_item(it);
  endtask

  // full register set of one voice in the current layout, mostly audible
  task automatic program_voice();
    int                         b;
    logic [wsg_pkg::BYTE_W-1:0] lvl;
    b = 5 * $urandom_range(0, wsg_pkg::VOICES - 1);
    lvl = wsg_pkg::BYTE_W'($urandom_range(1, 255));
    if (gen_layout && lvl[3:0] == 0)
      lvl[0] = 1'b1;
    if ($urandom_range(0, 9) == 0)
      lvl = '0;
    if (gen_layout) begin
      for (int k = 0; k < 5; k++)
        queue_reg(b + k, $urandom_range(0, 255));
      queue_reg(b + 5, lvl);
    end else begin
      if (b == 0)
        queue_reg('h10, $urandom_range(0, 255));
      for (int k = 1; k < 5; k++)
        queue_reg(b + 'h10 + k, $urandom_range(0, 255));
      queue_reg(b + 5, $urandom_range(0, 255));
      queue_reg(b + 'h15, lvl);
    end
  endtask

  // random mix: ticks and tick runs dominate, voices get reprogrammed as whole sets
  task automatic random_phase(input int n);
    int        stop;
    int        r;
    wsg_item_t it;
    stop = gen_count + n;
    while (gen_count < stop) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        queue_item(make_item(wsg_pkg::FUNC_TICK));
      end else if (r < 55) begin
        queue_item(make_item(wsg_pkg::FUNC_REG_WR));
      end else if (r < 65) begin
        program_voice();
      end else if (r < 72) begin
        it = make_item(wsg_pkg::FUNC_WAVE_WR);
        if ($urandom_range(0, 6) != 0)
          it.table_position = wsg_pkg::POS_W'($urandom_range(0, wsg_pkg::WAVE_LEN - 1));
        queue_item(it);
      end else if (r < 80) begin
        it = make_item(wsg_pkg::FUNC_BURST_WR);
        if ($urandom_range(0, 4) != 0)
          it.table_position = wsg_pkg::POS_W'($urandom_range(0, 127));
        queue_item(it);
      end else if (r < 84) begin
        it = make_item(wsg_pkg::FUNC_TRIGGER);
        it.game_running = ($urandom_range(0, 6) != 0);
        queue_item(it);
      end else if (r < 86) begin
        queue_item(make_item(wsg_pkg::FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))));
      end else begin
        repeat ($urandom_range(2, 8)) queue_item(make_item(wsg_pkg::FUNC_TICK));
      end
    end
  endtask

  task automatic set_config(input logic [wsg_pkg::CFG_IDX_W-1:0] idx,
                            input int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= wsg_pkg::CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (idx == wsg_pkg::CFG_LAYOUT)
      gen_layout = data[0];
    else if (idx == wsg_pkg::CFG_BURST)
      gen_burst_len = wsg_pkg::BLEN_W'(data);
  endtask

  // hold the sender until everything queued has come back, then let the block settle
  task automatic wait_idle();
    while (item_backlog.size() != 0 || in_ch.valid || pending_samples.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // model copy of the configuration registers
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        wsg_pkg::CFG_LAYOUT:  layout_q = cfg_data[0];
        wsg_pkg::CFG_PERCENT: percent_q = cfg_data[wsg_pkg::PCT_W-1:0];
        wsg_pkg::CFG_BURST:   burst_len_q = cfg_data[wsg_pkg::BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sender: bursts of items with random gaps between them
  int        gap_left = 0;
  int        run_left = 8;
  wsg_item_t live_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(live_item);
        items_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          live_item = item_backlog.pop_front();
          in_ch.func <= live_item.func;
          in_ch.reg_index <= live_item.reg_index;
          in_ch.reg_value <= live_item.reg_value;
          in_ch.wave_select <= live_item.wave_select;
          in_ch.table_position <= live_item.table_position;
          in_ch.sample_value <= live_item.sample_value;
          in_ch.game_running <= live_item.game_running;
          in_ch.valid <= 1'b1;
          if (run_left <= 1) begin
            run_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            run_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: periodic stall pattern with a re-drawn period and length, sometimes none
  int stall_period = 4;
  int stall_len    = 0;
  int stall_pos    = 0;
  int stall_age    = 0;

  always @(posedge clk) begin
    if (stall_age == 0) begin
      stall_age = 300;
      stall_period = $urandom_range(2, 16);
      stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
    end
    stall_age--;
    stall_pos = (stall_pos + 1) % stall_period;
    out_ch.ready <= (stall_pos >= stall_len);
  end

  // sample checker against the oldest predicted sample
  always @(posedge clk) begin : sample_check
    wsg_sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample: expected none, actual pcm %0d clipped %0b",
                 $time, out_ch.pcm_sample, out_ch.clipped);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (want.clipped)
          samples_clipped++;
        if (out_ch.pcm_sample !== want.pcm) begin
          errors++;
          $display("%0t: pcm_sample mismatch: expected %0d, actual %0d",
                   $time, want.pcm, out_ch.pcm_sample);
        end
        if (out_ch.clipped !== want.clipped) begin
          errors++;
          $display("%0t: clipped mismatch: expected %0b, actual %0b",
                   $time, want.clipped, out_ch.clipped);
        end
      end
    end
  end

  // main sequence
  initial begin
    wsg_item_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wsg_pkg::CFG_LAYOUT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = wsg_pkg::FUNC_TICK;
    in_ch.reg_index = '0;
    in_ch.reg_value = '0;
    in_ch.wave_select = '0;
    in_ch.table_position = '0;
    in_ch.sample_value = '0;
    in_ch.game_running = 1'b0;
    out_ch.ready = 1'b0;
    foreach (snd_reg[i]) snd_reg[i] = '0;
    for (int c = 0; c < wsg_pkg::VOICES; c++) begin
      voice_phase[c] = '0;
      voice_step[c] = '0;
      voice_wave[c] = '0;
      voice_level[c] = '0;
    end
    burst_left = '0;
    burst_ptr = '0;
    layout_q = 1'b0;
    percent_q = wsg_pkg::PCT_W'(100);
    burst_len_q = wsg_pkg::BLEN_RST;
    gen_layout = 1'b0;
    gen_burst_len = wsg_pkg::BLEN_RST;
    foreach (burst_loaded[i]) burst_loaded[i] = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // load every waveform entry, first two of each at the sample extremes
    for (int w = 0; w < 8; w++) begin
      for (int p = 0; p < wsg_pkg::WAVE_LEN; p++) begin
        it = make_item(wsg_pkg::FUNC_WAVE_WR);
        it.wave_select = wsg_pkg::WSEL_W'(w);
        it.table_position = wsg_pkg::POS_W'(p);
        if (p == 0)
          it.sample_value = -8'sd128;
        else if (p == 1)
          it.sample_value = 8'sd127;
        queue_item(it);
      end
    end

    // directed: silence, full level and step, saturation, a muted voice
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_reg('h15, 'hff);
    queue_reg('h05, 'h07);
    queue_reg('h10, 'hff);
    queue_reg('h14, 'hff);
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_reg('h1a, 'hff);
    queue_reg('h1f, 'hff);
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_reg('h1a, 'h00);
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    // waveform writes past the end of a waveform are dropped
    it = make_item(wsg_pkg::FUNC_WAVE_WR);
    it.table_position = wsg_pkg::POS_W'(wsg_pkg::WAVE_LEN);
    queue_item(it);
    it = make_item(wsg_pkg::FUNC_WAVE_WR);
    it.table_position = '1;
    queue_item(it);
    // burst bytes at both extremes and the top slot
    it = make_item(wsg_pkg::FUNC_BURST_WR);
    it.table_position = '0;
    it.sample_value = -8'sd128;
    queue_item(it);
    it = make_item(wsg_pkg::FUNC_BURST_WR);
    it.table_position = wsg_pkg::POS_W'(1);
    it.sample_value = 8'sd127;
    queue_item(it);
    it = make_item(wsg_pkg::FUNC_BURST_WR);
    it.table_position = '1;
    queue_item(it);
    // trigger while not running is ignored, then start and restart a burst
    it = make_item(wsg_pkg::FUNC_TRIGGER);
    it.game_running = 1'b0;
    queue_item(it);
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    it.game_running = 1'b1;
    queue_item(it);
    repeat (3) queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_item(it);
    queue_item(make_item(wsg_pkg::FUNC_TICK));
    queue_item(make_item(FUNC_SPARE_LO));
    queue_item(make_item(wsg_pkg::FUNC_W'(FUNC_SPARE_LO + 1'b1)));
    queue_item(make_item(FUNC_SPARE_HI));

    random_phase(ITEMS_PER_PHASE);
    wait_idle();

    // remaining register settings, extremes included
    for (int p = 0; p < PLAN_LEN; p++) begin
      set_config(wsg_pkg::CFG_LAYOUT, layout_plan[p]);
      set_config(wsg_pkg::CFG_PERCENT, percent_plan[p]);
      set_config(wsg_pkg::CFG_BURST, blen_plan[p]);
      if (p == 2)
        set_config(CFG_SPARE, $urandom);
      random_phase(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("Summary: %0d items driven, %0d samples compared, %0d of them saturated",
             items_sent, samples_checked, samples_clipped);
    $display("Summary: %0d register writes over %0d settings in both layouts",
             cfg_writes, PLAN_LEN + 1);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d samples still outstanding", $time, pending_samples.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[wavetable_sound_generator_unit.f]
sv/wsg_pkg.sv
sv/wsg_if.sv
sv/wsg_ctrl.sv
sv/wsg_dp.sv
sv/wavetable_sound_generator_unit.sv
tb/wavetable_sound_generator_unit_test.sv
